### rtl/minifloat_add_multiply_core_defines.svh
// Assertion macros for the core RTL file.
`ifndef MINIFLOAT_ADD_MULTIPLY_CORE_DEFINES_SVH
`define MINIFLOAT_ADD_MULTIPLY_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define MFAM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define MFAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define MFAM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MFAM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/mfam_pkg.sv
`timescale 1ns / 1ps

package mfam_pkg;

	localparam int EXP_BITS_DEF = 4;
	localparam int FRAC_BITS_DEF = 8;

	typedef enum logic {
		MODE_ADD = 1'b0,
		MODE_MUL = 1'b1
	} mode_t;

endpackage

### rtl/mfam_channels.sv
`timescale 1ns / 1ps

interface mfam_in_if
	import mfam_pkg::*;
#(
	parameter int EXP_BITS = EXP_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) ();
	logic valid;
	logic ready;
	mode_t mode;
	logic [EXP_BITS+FRAC_BITS-1:0] operand_a;
	logic [EXP_BITS+FRAC_BITS-1:0] operand_b;

	modport source (output valid, output mode, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input mode, input operand_a, input operand_b,
		output ready);
endinterface

interface mfam_out_if
	import mfam_pkg::*;
#(
	parameter int EXP_BITS = EXP_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) ();
	logic valid;
	logic ready;
	logic [EXP_BITS+FRAC_BITS-1:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

### rtl/minifloat_add_multiply_core.sv
`timescale 1ns / 1ps
`include "minifloat_add_multiply_core_defines.svh"

// Channel    Role    Word
// operands   sink    mode, operand_a, operand_b
// results    source  result
//
// One word is accepted every cycle unless both registers are full and the
// result is stalled; the input register and the result register each hold
// one word, and a single pass of add or multiply, normalise and encode lies
// between them.
// Reset clears only the two valid flags.
// A stalled result holds the result register; the input register still takes
// a word while it is empty.

module minifloat_add_multiply_core
	import mfam_pkg::*;
#(
	parameter int EXP_BITS = EXP_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	mfam_in_if.sink operands,
	mfam_out_if.source results
);

	localparam int WORD_W = EXP_BITS + FRAC_BITS;
	localparam int SIG_W = FRAC_BITS + 1;
	localparam int BIAS = (1 << (EXP_BITS - 1)) - 1;
	localparam int MAX_EXP = (1 << EXP_BITS) - 2;
	localparam int SUM_W = 2 * FRAC_BITS + 3;
	localparam int DC_MAX = FRAC_BITS + 1;
	localparam int DC_W = $clog2(DC_MAX + 1);
	localparam int LZ_STEPS = $clog2(SUM_W);
	localparam int XW = $clog2((1 << (EXP_BITS + 1)) + 2 * FRAC_BITS + 8) + 1;
	localparam int SH_W = $clog2(FRAC_BITS + 1);
	localparam logic [WORD_W-1:0] SAT_CODE = {{EXP_BITS{1'b1}}, {FRAC_BITS{1'b0}}};

	logic vld_s1;
	logic vld_s2;
	logic adv_s2;
	logic in_rdy;
	mode_t mode_s1;
	logic [WORD_W-1:0] a_s1;
	logic [WORD_W-1:0] b_s1;
	logic [WORD_W-1:0] result_s2;
	logic mul_zero_s1;

	logic [EXP_BITS-1:0] ea, eb, eff_a, eff_b, hi_eff, lo_eff, diff;
	logic [SIG_W-1:0] ma, mb, hi_m, lo_m;
	logic a_hi;
	logic [DC_W-1:0] dc;
	logic [SUM_W-1:0] m_add, m_mul, m_c;
	logic [2*SIG_W-1:0] prod;
	logic signed [XW-1:0] t_add, t_mul, t_c, ex_c, sub_sh_c;
	logic [SUM_W-1:0] norm_v [LZ_STEPS+1];
	logic [LZ_STEPS-1:0] lz_v [LZ_STEPS+1];
	logic [SIG_W-1:0] top_c, sub_fr;
	logic [WORD_W-1:0] res_c;

	assign adv_s2 = !vld_s2 || results.ready;
	assign in_rdy = !vld_s1 || adv_s2;
	assign operands.ready = in_rdy;
	assign results.valid = vld_s2;
	assign results.result = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_rdy) begin
				vld_s1 <= operands.valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && operands.valid) begin
			mode_s1 <= operands.mode;
			a_s1 <= operands.operand_a;
			b_s1 <= operands.operand_b;
		end
		if (adv_s2 && vld_s1) begin
			result_s2 <= res_c;
		end
	end

	// A zero exponent field marks a subnormal, which shares the scale of exponent one.
	assign ea = a_s1[WORD_W-1:FRAC_BITS];
	assign eb = b_s1[WORD_W-1:FRAC_BITS];
	assign eff_a = (ea == '0) ? EXP_BITS'(1) : ea;
	assign eff_b = (eb == '0) ? EXP_BITS'(1) : eb;
	assign ma = {(ea != '0), a_s1[FRAC_BITS-1:0]};
	assign mb = {(eb != '0), b_s1[FRAC_BITS-1:0]};

	// Beyond a gap of one more than the fraction width the smaller addend sits
	// wholly below the kept bits, so the alignment is capped there.
	assign a_hi = (eff_a >= eff_b);
	assign hi_eff = a_hi ? eff_a : eff_b;
	assign lo_eff = a_hi ? eff_b : eff_a;
	assign hi_m = a_hi ? ma : mb;
	assign lo_m = a_hi ? mb : ma;
	assign diff = hi_eff - lo_eff;
	assign dc = (diff > DC_MAX) ? DC_W'(DC_MAX) : DC_W'(diff);
	assign m_add = (SUM_W'(hi_m) << dc) + SUM_W'(lo_m);
	assign t_add = $signed(XW'(hi_eff)) - $signed(XW'(dc)) - XW'(1);

	assign prod = ma * mb;
	assign m_mul = SUM_W'(prod);
	assign t_mul = $signed(XW'(eff_a)) + $signed(XW'(eff_b)) - XW'(BIAS + FRAC_BITS + 1);

	assign m_c = (mode_s1 == MODE_MUL) ? m_mul : m_add;
	assign t_c = (mode_s1 == MODE_MUL) ? t_mul : t_add;

	assign norm_v[0] = m_c;
	assign lz_v[0] = '0;
	for (genvar g = 0; g < LZ_STEPS; g++) begin : g_norm
		localparam int SH = 1 << (LZ_STEPS - 1 - g);
		logic zero_top;
		assign zero_top = (norm_v[g][SUM_W-1 -: SH] == '0);
		assign norm_v[g+1] = zero_top ? (norm_v[g] << SH) : norm_v[g];
		assign lz_v[g+1] = lz_v[g] + (zero_top ? LZ_STEPS'(SH) : '0);
	end

	assign ex_c = t_c + XW'(SUM_W - FRAC_BITS) - XW'(lz_v[LZ_STEPS]);
	assign sub_sh_c = XW'(1) - ex_c;
	assign top_c = norm_v[LZ_STEPS][SUM_W-1 -: SIG_W];
	assign sub_fr = top_c >> sub_sh_c[SH_W-1:0];

	always_comb begin
		if (m_c == '0) begin
			res_c = '0;
		end else if (ex_c > $signed(XW'(MAX_EXP))) begin
			res_c = SAT_CODE;
		end else if (ex_c >= $signed(XW'(1))) begin
			res_c = {ex_c[EXP_BITS-1:0], norm_v[LZ_STEPS][SUM_W-2 -: FRAC_BITS]};
		end else if (sub_sh_c > $signed(XW'(FRAC_BITS))) begin
			res_c = '0;
		end else begin
			res_c = {EXP_BITS'(0), sub_fr[FRAC_BITS-1:0]};
		end
	end

	assign mul_zero_s1 = (mode_s1 == MODE_MUL) && (a_s1 == '0 || b_s1 == '0);

	`MFAM_ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, vld_s1 && vld_s2 && !results.ready, !in_rdy)
	`MFAM_ASSERT_NEXT(a_take_fills, clk, arst_n, operands.valid && in_rdy, vld_s1)
	`MFAM_ASSERT_IMPLIES(a_result_range, clk, arst_n, vld_s2, result_s2 <= SAT_CODE)
	`MFAM_ASSERT_NEXT(a_mul_zero, clk, arst_n, vld_s1 && adv_s2 && mul_zero_s1, result_s2 == '0)

endmodule

### tb/mfam_result_checker.sv
`timescale 1ns / 1ps

module mfam_result_checker
	import mfam_pkg::*;
(
	input logic clk,
	input logic arst_n,
	mfam_in_if operands,
	mfam_out_if results,
	output int errors,
	output int pending,
	output int checked,
	output int saturated,
	output int zeros
);

	localparam int EB = EXP_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int W = EB + FB;
	localparam int BIAS = (1 << (EB - 1)) - 1;
	localparam int MAX_EXP = (1 << EB) - 2;
	localparam int MIN_SCALE = 1 - BIAS - FB;
	localparam logic [W-1:0] SAT_CODE = {{EB{1'b1}}, {FB{1'b0}}};

	logic [W-1:0] expected_results[$];
	int err_n = 0;
	int checked_n = 0;
	int sat_n = 0;
	int zero_n = 0;

	function automatic void unpack_operand(input logic [W-1:0] word, output logic [63:0] sig,
		output int scale);
		logic [EB-1:0] ex;
		ex = word[W-1:FB];
		sig = 64'(word[FB-1:0]);
		if (ex == '0) begin
			scale = MIN_SCALE;
		end else begin
			sig[FB] = 1'b1;
			scale = int'(ex) - BIAS - FB;
		end
	endfunction

	function automatic logic [W-1:0] predict_result(mode_t op, logic [W-1:0] a,
		logic [W-1:0] b);
		logic [63:0] sig_a, sig_b, sig, swap_sig, frac;
		int sc_a, sc_b, sc, swap_sc, gap, msb, e, ex, sh;
		logic [W-1:0] word;
		unpack_operand(a, sig_a, sc_a);
		unpack_operand(b, sig_b, sc_b);
		if (op == MODE_MUL) begin
			sig = sig_a * sig_b;
			sc = sc_a + sc_b;
		end else begin
			if (sc_a < sc_b) begin
				swap_sig = sig_a;
				swap_sc = sc_a;
				sig_a = sig_b;
				sc_a = sc_b;
				sig_b = swap_sig;
				sc_b = swap_sc;
			end
			gap = sc_a - sc_b;
			if (gap >= 32) begin
				sig = sig_a;
				sc = sc_a;
			end else begin
				sig = (sig_a << gap) + sig_b;
				sc = sc_b;
			end
		end
		if (sig == 64'd0)
			return '0;
		msb = 0;
		for (int i = 0; i < 64; i++)
			if (sig[i])
				msb = i;
		e = msb + sc;
		if (e < MIN_SCALE)
			return '0;
		ex = e + BIAS;
		if (ex > MAX_EXP)
			return SAT_CODE;
		if (ex >= 1) begin
			if (msb >= FB)
				frac = sig >> (msb - FB);
			else
				frac = sig << (FB - msb);
		end else begin
			ex = 0;
			sh = sc - MIN_SCALE;
			if (sh >= 0)
				frac = sig << sh;
			else
				frac = sig >> (-sh);
		end
		word[W-1:FB] = ex[EB-1:0];
		word[FB-1:0] = frac[FB-1:0];
		return word;
	endfunction

	always @(posedge clk) begin
		logic [W-1:0] want;
		if (arst_n) begin
			if (results.valid && results.ready) begin
				if (expected_results.size() == 0) begin
					err_n++;
					$display("%0t: unexpected result, expected none, actual %03h", $time,
						results.result);
				end else begin
					want = expected_results.pop_front();
					checked_n++;
					if (results.result !== want) begin
						err_n++;
						$display("%0t: result mismatch, expected %03h, actual %03h", $time,
							want, results.result);
					end
				end
			end
			if (operands.valid && operands.ready) begin
				want = predict_result(operands.mode, operands.operand_a, operands.operand_b);
				if (want == SAT_CODE)
					sat_n++;
				if (want == '0)
					zero_n++;
				expected_results.push_back(want);
			end
		end
		errors <= err_n;
		pending <= expected_results.size();
		checked <= checked_n;
		saturated <= sat_n;
		zeros <= zero_n;
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import mfam_pkg::*;

	localparam int W = EXP_BITS_DEF + FRAC_BITS_DEF;
	localparam int RANDOM_WORDS = 450;
	localparam int IDLE_LIMIT = 1000;

	typedef struct {
		mode_t op;
		logic [W-1:0] a;
		logic [W-1:0] b;
	} operand_word_t;

	logic clk = 1'b0;
	logic arst_n;
	int errors, pending, checked, saturated, zeros;
	int idle_cycles = 0;
	int add_words = 0;
	int mul_words = 0;
	operand_word_t operand_words[$];

	mfam_in_if operands_ch ();
	mfam_out_if results_ch ();

	minifloat_add_multiply_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.operands(operands_ch),
		.results(results_ch)
	);

	mfam_result_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.operands(operands_ch),
		.results(results_ch),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.saturated(saturated),
		.zeros(zeros)
	);

	always #5 clk = ~clk;

	function automatic logic [W-1:0] rand_operand();
		logic [W-1:0] word;
		word = W'($urandom);
		case ($urandom_range(0, 3))
			0: ;
			1: word[W-1:FRAC_BITS_DEF] = '0;
			2: word[W-1:FRAC_BITS_DEF] = EXP_BITS_DEF'($urandom_range(5, 9));
			default: word[W-1:FRAC_BITS_DEF] = EXP_BITS_DEF'($urandom_range(13, 15));
		endcase
		return word;
	endfunction

	function automatic void add_word(mode_t op, logic [W-1:0] a, logic [W-1:0] b);
		operand_word_t w;
		w.op = op;
		w.a = a;
		w.b = b;
		operand_words.push_back(w);
	endfunction

	initial begin
		int burst_left;
		int gap;
		arst_n = 1'b0;
		operands_ch.valid <= 1'b0;
		operands_ch.mode <= MODE_ADD;
		operands_ch.operand_a <= '0;
		operands_ch.operand_b <= '0;

		add_word(MODE_ADD, 12'h000, 12'h000);
		add_word(MODE_ADD, 12'hFFF, 12'hFFF);
		add_word(MODE_ADD, 12'h001, 12'h001);
		add_word(MODE_ADD, 12'h0FF, 12'h001);
		add_word(MODE_ADD, 12'hF00, 12'h000);
		add_word(MODE_ADD, 12'hE00, 12'h000);
		add_word(MODE_ADD, 12'hEFF, 12'hEFF);
		add_word(MODE_ADD, 12'hE00, 12'h001);
		add_word(MODE_ADD, 12'h700, 12'h700);
		add_word(MODE_ADD, 12'h7FF, 12'h001);
		add_word(MODE_ADD, 12'h001, 12'hFFF);
		add_word(MODE_ADD, 12'h100, 12'h0FF);
		add_word(MODE_MUL, 12'h000, 12'hFFF);
		add_word(MODE_MUL, 12'hFFF, 12'hFFF);
		add_word(MODE_MUL, 12'h001, 12'h001);
		add_word(MODE_MUL, 12'h001, 12'hF00);
		add_word(MODE_MUL, 12'h700, 12'hABC);
		add_word(MODE_MUL, 12'h100, 12'h100);
		add_word(MODE_MUL, 12'h080, 12'h080);
		add_word(MODE_MUL, 12'h0FF, 12'h700);
		add_word(MODE_MUL, 12'h300, 12'h300);
		add_word(MODE_MUL, 12'h5A5, 12'hC3C);
		add_word(MODE_MUL, 12'hE00, 12'h700);
		add_word(MODE_MUL, 12'h700, 12'h001);
		for (int i = 0; i < RANDOM_WORDS; i++)
			add_word($urandom_range(0, 1) ? MODE_MUL : MODE_ADD, rand_operand(), rand_operand());

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_left = $urandom_range(1, 30);
		foreach (operand_words[i]) begin
			operands_ch.valid <= 1'b1;
			operands_ch.mode <= operand_words[i].op;
			operands_ch.operand_a <= operand_words[i].a;
			operands_ch.operand_b <= operand_words[i].b;
			@(posedge clk);
			while (!operands_ch.ready)
				@(posedge clk);
			if (operand_words[i].op == MODE_MUL)
				mul_words++;
			else
				add_words++;
			burst_left--;
			if (burst_left == 0) begin
				operands_ch.valid <= 1'b0;
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 30);
			end
		end
		operands_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d add and %0d multiply words, %0d results checked.", add_words,
			mul_words, checked);
		$display("Expected results included %0d saturated and %0d zero words.", saturated, zeros);
		if (errors == 0) begin
			$display("minifloat_add_multiply_core test passed");
		end else begin
			$display("minifloat_add_multiply_core test failed");
		end
		$finish;
	end

	initial begin
		int kind;
		int len;
		results_ch.ready <= 1'b0;
		forever begin
			kind = $urandom_range(0, 3);
			len = (kind == 2) ? $urandom_range(1, 12) : $urandom_range(10, 60);
			repeat (len) begin
				@(posedge clk);
				case (kind)
					0: results_ch.ready <= 1'b1;
					1: results_ch.ready <= 1'($urandom_range(0, 1));
					2: results_ch.ready <= 1'b0;
					default: results_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((operands_ch.valid && operands_ch.ready) || (results_ch.valid && results_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog expired after %0d cycles with no word accepted.", idle_cycles);
				$display("minifloat_add_multiply_core test failed");
				$finish;
			end
		end
	end

endmodule
